// ===== design/chsb_pkg.sv =====
package chsb_pkg;

  // component width and fraction bits of the vector words
  localparam int CB = 16;
  localparam int FB = CB - 2;
  localparam int VW = 3 * CB;

  // angle math runs in Q2.30
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

  // Horner steps: divide by k = 2^A * d as a shift, then a reciprocal
  // multiply M = ceil(2^S / d) with S = 30 + ceil(log2 d), exact below 2^30
  localparam int HSTEPS = 6;
  localparam int SIN_A [HSTEPS] = '{1, 3, 1, 2, 1, 0};
  localparam int SIN_S [HSTEPS] = '{36, 34, 35, 33, 32, 0};
  localparam longint unsigned SIN_M [HSTEPS] = '{
    ((64'd1 << 36) + 64'd54) / 64'd55,
    ((64'd1 << 34) + 64'd8) / 64'd9,
    ((64'd1 << 35) + 64'd20) / 64'd21,
    ((64'd1 << 33) + 64'd4) / 64'd5,
    ((64'd1 << 32) + 64'd2) / 64'd3,
    64'd0
  };
  localparam int COS_A [HSTEPS] = '{2, 1, 3, 1, 2, 1};
  localparam int COS_S [HSTEPS] = '{36, 36, 33, 34, 32, 30};
  localparam longint unsigned COS_M [HSTEPS] = '{
    ((64'd1 << 36) + 64'd32) / 64'd33,
    ((64'd1 << 36) + 64'd44) / 64'd45,
    ((64'd1 << 33) + 64'd6) / 64'd7,
    ((64'd1 << 34) + 64'd14) / 64'd15,
    ((64'd1 << 32) + 64'd2) / 64'd3,
    64'd1 << 30
  };

  // pipeline map
  localparam int TRIG_LAT = 16;
  localparam int SQ_LAT   = 8;
  localparam int SQ_PAIRS = 31;
  localparam int DIV_STG  = (CB + 3) / 4;
  localparam int S_COL    = 1 + DIV_STG;
  localparam int S_XY     = TRIG_LAT + 1;
  localparam int S_PR     = TRIG_LAT + 2;
  localparam int S_SUM    = TRIG_LAT + 3;
  localparam int LAT      = TRIG_LAT + 4;

  typedef logic signed [31:0] trig_t;
  typedef logic [30:0]        root_t;

endpackage

// ===== design/chsb_sqrt.sv =====
module chsb_sqrt import chsb_pkg::*; (
  input  logic            clk,
  input  logic [SQ_LAT:1] en,
  input  logic [CB:0]     operand,
  output root_t           root
);

  typedef struct packed {
    logic [33:0] rem;
    logic [30:0] root;
    logic [61:0] rad;
  } sq_t;

  function automatic sq_t sq_step(sq_t s);
    logic [33:0] r2;
    logic [33:0] tr;
    sq_t         o;
    r2 = {s.rem[31:0], s.rad[61:60]};
    tr = {1'b0, s.root, 2'b01};
    o.rad = s.rad << 2;
    if (r2 >= tr) begin
      o.rem  = r2 - tr;
      o.root = {s.root[29:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[29:0], 1'b0};
    end
    return o;
  endfunction

  sq_t st_r  [1:SQ_LAT];
  sq_t prv   [1:SQ_LAT];
  sq_t nxt   [1:SQ_LAT];

  // radicand is operand * 2^(60-CB), root in Q2.30
  assign prv[1] = '{rem: '0, root: '0, rad: 62'(operand) << (60 - CB)};

  for (genvar k = 1; k <= SQ_LAT; k++) begin : g_stg
    if (k > 1) begin : g_link
      assign prv[k] = st_r[k-1];
    end

    always_comb begin
      nxt[k] = prv[k];
      for (int i = 0; i < 4; i++) begin
        if ((k - 1) * 4 + i < SQ_PAIRS) begin
          nxt[k] = sq_step(nxt[k]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= nxt[k];
      end
    end
  end

  assign root = st_r[SQ_LAT].root;

endmodule

// ===== design/chsb_trig.sv =====
module chsb_trig import chsb_pkg::*; (
  input  logic              clk,
  input  logic [TRIG_LAT:1] en,
  input  logic [CB-1:0]     angle,
  output trig_t             cos_val,
  output trig_t             sin_val
);

  // quarter turn split
  logic [CB:0]          usum;
  logic [2:0]           q1;
  logic signed [CB+1:0] r1;
  logic signed [CB+1:0] r1_abs;

  logic [2:0]    q_r   [1:15];
  logic          ng_r  [1:15];
  logic [CB-3:0] mag_r;
  logic [29:0]   a_r   [2:13];
  logic [29:0]   x2_r  [3:13];

  logic [CB+30:0] a_prod;
  logic [59:0]    x2_prod;

  logic [29:0] ps_r   [HSTEPS];
  logic [29:0] pc_r   [HSTEPS];
  logic [30:0] sacc_r [HSTEPS];
  logic [30:0] cacc_r [HSTEPS];

  trig_t sv;
  trig_t cv;
  trig_t co_r;
  trig_t si_r;

  always_comb begin
    usum    = {1'b0, angle} + (CB+1)'(1 << (CB - 3));
    q1      = 3'(usum >> (CB - 2));
    r1      = $signed({2'b00, angle}) - $signed({1'b0, (CB+1)'(q1) << (CB - 2)});
    r1_abs  = (r1 < 0) ? -r1 : r1;
    a_prod  = (CB+31)'(mag_r) * (CB+31)'(TWO_PI_Q30);
    x2_prod = 60'(a_r[2]) * 60'(a_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q_r[1]  <= q1;
      ng_r[1] <= (r1 < 0);
      mag_r   <= r1_abs[CB-3:0];
    end
    if (en[2]) begin
      a_r[2] <= 30'(a_prod >> CB);
    end
    if (en[3]) begin
      x2_r[3] <= 30'(x2_prod >> 30);
    end
    for (int k = 2; k <= 15; k++) begin
      if (en[k]) begin
        q_r[k]  <= q_r[k-1];
        ng_r[k] <= ng_r[k-1];
      end
    end
    for (int k = 3; k <= 13; k++) begin
      if (en[k]) begin
        a_r[k] <= a_r[k-1];
      end
    end
    for (int k = 4; k <= 13; k++) begin
      if (en[k]) begin
        x2_r[k] <= x2_r[k-1];
      end
    end
  end

  // Horner chains, two stages a step: product, then reciprocal divide
  for (genvar j = 0; j < HSTEPS; j++) begin : g_hrn
    logic [30:0] s_in;
    logic [30:0] c_in;
    logic [60:0] sp;
    logic [60:0] cp;
    logic [61:0] sq;
    logic [61:0] cq;

    if (j == 0) begin : g_first
      assign s_in = ONE_Q30;
      assign c_in = ONE_Q30;
    end else begin : g_next
      assign s_in = sacc_r[j-1];
      assign c_in = cacc_r[j-1];
    end

    // last sine step scales by the angle itself
    if (j == HSTEPS - 1) begin : g_slast
      assign sp = 61'(a_r[3+2*j]) * 61'(s_in);
      assign sq = 62'(ps_r[j]);
    end else begin : g_sstep
      assign sp = 61'(x2_r[3+2*j]) * 61'(s_in);
      assign sq = (62'(ps_r[j]) * 62'(SIN_M[j])) >> SIN_S[j];
    end
    assign cp = 61'(x2_r[3+2*j]) * 61'(c_in);
    assign cq = (62'(pc_r[j]) * 62'(COS_M[j])) >> COS_S[j];

    always_ff @(posedge clk) begin
      if (en[4+2*j]) begin
        if (j == HSTEPS - 1) begin
          ps_r[j] <= 30'(sp >> 30);
        end else begin
          ps_r[j] <= 30'((sp >> 30) >> SIN_A[j]);
        end
        pc_r[j] <= 30'((cp >> 30) >> COS_A[j]);
      end
      if (en[5+2*j]) begin
        if (j == HSTEPS - 1) begin
          sacc_r[j] <= 31'(sq);
        end else begin
          sacc_r[j] <= ONE_Q30 - 31'(sq);
        end
        cacc_r[j] <= ONE_Q30 - 31'(cq);
      end
    end
  end

  // fold the quarter turn back in
  always_comb begin
    cv = trig_t'(cacc_r[HSTEPS-1]);
    sv = ng_r[15] ? -trig_t'(sacc_r[HSTEPS-1]) : trig_t'(sacc_r[HSTEPS-1]);
  end

  always_ff @(posedge clk) begin
    if (en[16]) begin
      case (q_r[15][1:0])
        2'd0: begin
          co_r <= cv;
          si_r <= sv;
        end
        2'd1: begin
          co_r <= -sv;
          si_r <= cv;
        end
        2'd2: begin
          co_r <= -cv;
          si_r <= -sv;
        end
        default: begin
          co_r <= sv;
          si_r <= -cv;
        end
      endcase
    end
  end

  assign cos_val = co_r;
  assign sin_val = si_r;

endmodule

// ===== design/cosine_hemisphere_bounce_sampler.sv =====
// Cosine-weighted hemisphere bounce sampler. One word in, one word out, one
// word per clock sustained while the output is ready; the path is the angle unit
// (quarter-turn reduction, six two-stage Horner steps for sine and cosine,
// quadrant fold) followed by the scale, the 3x3 basis multiply, the sum and
// the saturation stages. Roulette survives when 3*rand_roulette is below
// R+G+B. On survival the normal is flipped toward the incoming side, the
// bitangent is normal x tangent, and the direction is
// t*cos*sqrt(v) + c*sin*sqrt(v) + n*sqrt(1-v), rounded to Q1.14 and
// saturated; color is 3*refl/(R+G+B) in Q2.14. A terminated path gives all
// zeros; a zero direction gives bounce_valid low with color still set.
// Stalls on the output back up stage by stage, so empty stages keep filling.
module cosine_hemisphere_bounce_sampler import chsb_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [VW-1:0] in_surface_normal,
  input  logic [VW-1:0] in_surface_tangent,
  input  logic [VW-1:0] in_incoming_direction,
  input  logic [VW-1:0] in_surface_reflectivity,
  input  logic [CB-1:0] in_rand_roulette,
  input  logic [CB-1:0] in_rand_angle,
  input  logic [CB-1:0] in_rand_radius,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_bounce_valid,
  output logic [VW-1:0] out_outgoing_direction,
  output logic [VW-1:0] out_bounce_color
);

  localparam int NW = 2 * CB + 2;   // color numerator
  localparam int RW = CB + 4;       // divider remainder
  localparam int PW = CB + 36;      // basis products
  localparam int AW = CB + 38;      // direction sum
  localparam int CW = AW - 30;      // rounded component before clamp
  localparam logic signed [CW-1:0] SAT_HI = CW'((1 << (CB - 1)) - 1);
  localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;

  // ---------------- handshake: per-stage valid, ready ripples back
  logic [LAT:1]   vld_r;
  logic [LAT:1]   vin;
  logic [LAT+1:1] rdy;
  logic [LAT:1]   en;

  always_comb begin
    rdy[LAT+1] = out_ready;
    for (int k = LAT; k >= 1; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  assign en       = rdy[LAT:1];
  assign vin      = {vld_r[LAT-1:1], in_valid};
  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= LAT; k++) begin
        if (en[k]) begin
          vld_r[k] <= vin[k];
        end
      end
    end
  end

  // ---------------- stage 1: unpack, roulette, color numerators, n.d terms
  logic signed [CB-1:0] n_in  [3];
  logic signed [CB-1:0] t_in  [3];
  logic signed [CB-1:0] d_in  [3];
  logic [CB-1:0]        rf_in [3];
  logic [CB+1:0]        sum_c;
  logic                 surv_c;
  logic [NW-1:0]        num_c [3];
  logic signed [2*CB-1:0] nd_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_in[i]  = in_surface_normal[i*CB +: CB];
      t_in[i]  = in_surface_tangent[i*CB +: CB];
      d_in[i]  = in_incoming_direction[i*CB +: CB];
      rf_in[i] = in_surface_reflectivity[i*CB +: CB];
    end
    sum_c  = (CB+2)'(rf_in[0]) + (CB+2)'(rf_in[1]) + (CB+2)'(rf_in[2]);
    surv_c = ((CB+2)'(in_rand_roulette) * (CB+2)'(3)) < sum_c;
    for (int i = 0; i < 3; i++) begin
      num_c[i] = ((NW'(rf_in[i]) * NW'(3)) << (FB + 1)) + NW'(sum_c);
      nd_c[i]  = n_in[i] * d_in[i];
    end
  end

  logic                   surv_r [1:S_SUM];
  logic [NW-1:0]          num_r  [3];
  logic [CB+2:0]          den_r;
  logic signed [2*CB-1:0] nd_r   [3];
  logic signed [CB-1:0]   n1_r   [3];
  logic signed [CB-1:0]   t_r    [1:S_XY][3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      surv_r[1] <= surv_c;
      num_r     <= num_c;
      den_r     <= {sum_c, 1'b0};
      nd_r      <= nd_c;
      n1_r      <= n_in;
      t_r[1]    <= t_in;
    end
    for (int k = 2; k <= S_SUM; k++) begin
      if (en[k]) begin
        surv_r[k] <= surv_r[k-1];
      end
    end
    for (int k = 2; k <= S_XY; k++) begin
      if (en[k]) begin
        t_r[k] <= t_r[k-1];
      end
    end
  end

  // ---------------- stage 2: flip normal toward the incoming side
  logic signed [2*CB+1:0] dot_c;
  logic signed [CB:0]     ne_c [3];
  logic signed [CB:0]     nf_r [2:S_XY][3];

  always_comb begin
    dot_c = (2*CB+2)'(nd_r[0]) + (2*CB+2)'(nd_r[1]) + (2*CB+2)'(nd_r[2]);
    for (int i = 0; i < 3; i++) begin
      ne_c[i] = n1_r[i];
      if (dot_c < 0) begin
        ne_c[i] = -ne_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      nf_r[2] <= ne_c;
    end
    for (int k = 3; k <= S_XY; k++) begin
      if (en[k]) begin
        nf_r[k] <= nf_r[k-1];
      end
    end
  end

  // ---------------- stages 3-4: bitangent c = n x t, floored to Q5.14
  logic signed [2*CB:0]   xa_r [3];
  logic signed [2*CB:0]   xb_r [3];
  logic signed [2*CB+1:0] xd_c [3];
  logic signed [CB+3:0]   c_r  [4:S_XY][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xd_c[i] = (2*CB+2)'(xa_r[i]) - (2*CB+2)'(xb_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      xa_r[0] <= nf_r[2][1] * t_r[2][2];
      xb_r[0] <= nf_r[2][2] * t_r[2][1];
      xa_r[1] <= nf_r[2][2] * t_r[2][0];
      xb_r[1] <= nf_r[2][0] * t_r[2][2];
      xa_r[2] <= nf_r[2][0] * t_r[2][1];
      xb_r[2] <= nf_r[2][1] * t_r[2][0];
    end
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        c_r[4][i] <= xd_c[i][2*CB+1:FB];
      end
    end
    for (int k = 5; k <= S_XY; k++) begin
      if (en[k]) begin
        c_r[k] <= c_r[k-1];
      end
    end
  end

  // ---------------- color: restoring divide, four quotient bits a stage
  logic [RW-1:0] drem_r [DIV_STG][3];
  logic [CB-1:0] dquo_r [DIV_STG][3];
  logic [NW-1:0] dnum_r [DIV_STG][3];
  logic [CB+2:0] dden_r [DIV_STG];

  for (genvar j = 0; j < DIV_STG; j++) begin : g_div
    logic [RW-1:0] rem_in [3];
    logic [CB-1:0] quo_in [3];
    logic [NW-1:0] num_in [3];
    logic [CB+2:0] den_in;
    logic [RW-1:0] rem_c  [3];
    logic [CB-1:0] quo_c  [3];

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = RW'(num_r[i] >> CB);
          quo_in[i] = '0;
        end
      end
      assign num_in = num_r;
      assign den_in = den_r;
    end else begin : g_next
      assign rem_in = drem_r[j-1];
      assign quo_in = dquo_r[j-1];
      assign num_in = dnum_r[j-1];
      assign den_in = dden_r[j-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_c[i] = rem_in[i];
        quo_c[i] = quo_in[i];
        for (int b = 0; b < 4; b++) begin
          if (4 * j + b < CB) begin
            rem_c[i] = {rem_c[i][RW-2:0], num_in[i][CB-1-(4*j+b)]};
            if (rem_c[i] >= RW'(den_in)) begin
              rem_c[i] = rem_c[i] - RW'(den_in);
              quo_c[i][CB-1-(4*j+b)] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[2+j]) begin
        drem_r[j] <= rem_c;
        dquo_r[j] <= quo_c;
        dnum_r[j] <= num_in;
        dden_r[j] <= den_in;
      end
    end
  end

  // quotient never exceeds 3*2^14 since each channel is at most the sum
  logic [CB-1:0] col_r [S_COL+1:S_SUM][3];

  always_ff @(posedge clk) begin
    if (en[S_COL+1]) begin
      col_r[S_COL+1] <= dquo_r[DIV_STG-1];
    end
    for (int k = S_COL + 2; k <= S_SUM; k++) begin
      if (en[k]) begin
        col_r[k] <= col_r[k-1];
      end
    end
  end

  // ---------------- angle and radial terms
  trig_t co_s;
  trig_t si_s;
  root_t sr_s;
  root_t sz_s;
  root_t sr_r [SQ_LAT+1:TRIG_LAT];
  root_t sz_r [SQ_LAT+1:TRIG_LAT];

  chsb_trig u_trig (
    .clk     (clk),
    .en      (en[TRIG_LAT:1]),
    .angle   (in_rand_angle),
    .cos_val (co_s),
    .sin_val (si_s)
  );

  chsb_sqrt u_sqrt_r (
    .clk     (clk),
    .en      (en[SQ_LAT:1]),
    .operand ((CB+1)'(in_rand_radius)),
    .root    (sr_s)
  );

  chsb_sqrt u_sqrt_z (
    .clk     (clk),
    .en      (en[SQ_LAT:1]),
    .operand ({1'b1, {CB{1'b0}}} - (CB+1)'(in_rand_radius)),
    .root    (sz_s)
  );

  always_ff @(posedge clk) begin
    if (en[SQ_LAT+1]) begin
      sr_r[SQ_LAT+1] <= sr_s;
      sz_r[SQ_LAT+1] <= sz_s;
    end
    for (int k = SQ_LAT + 2; k <= TRIG_LAT; k++) begin
      if (en[k]) begin
        sr_r[k] <= sr_r[k-1];
        sz_r[k] <= sz_r[k-1];
      end
    end
  end

  // ---------------- stage 17: disk coordinates, floored to Q2.30
  logic signed [63:0] xp_c;
  logic signed [63:0] yp_c;
  trig_t xc_r;
  trig_t yc_r;
  trig_t zc_r;

  assign xp_c = co_s * $signed({1'b0, sr_r[TRIG_LAT]});
  assign yp_c = si_s * $signed({1'b0, sr_r[TRIG_LAT]});

  always_ff @(posedge clk) begin
    if (en[S_XY]) begin
      xc_r <= xp_c[61:30];
      yc_r <= yp_c[61:30];
      zc_r <= $signed({1'b0, sz_r[TRIG_LAT]});
    end
  end

  // ---------------- stage 18: basis products
  logic signed [PW-1:0] pt_r [3];
  logic signed [PW-1:0] pc_r [3];
  logic signed [PW-1:0] pn_r [3];

  always_ff @(posedge clk) begin
    if (en[S_PR]) begin
      for (int i = 0; i < 3; i++) begin
        pt_r[i] <= PW'(t_r[S_XY][i] * xc_r);
        pc_r[i] <= PW'(c_r[S_XY][i] * yc_r);
        pn_r[i] <= PW'(nf_r[S_XY][i] * zc_r);
      end
    end
  end

  // ---------------- stage 19: sum, round half up
  logic signed [AW-1:0] acc_c [3];
  logic signed [CW-1:0] cmp_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_c[i] = AW'(pt_r[i]) + AW'(pc_r[i]) + AW'(pn_r[i]) + (AW'(1) <<< 29);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_SUM]) begin
      for (int i = 0; i < 3; i++) begin
        cmp_r[i] <= acc_c[i][AW-1:30];
      end
    end
  end

  // ---------------- stage 20: clamp, zero test, output word
  logic [VW-1:0] dir_c;
  logic [VW-1:0] col_c;
  logic          nz_c;
  logic          ob_r;
  logic [VW-1:0] od_r;
  logic [VW-1:0] oc_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cmp_r[i] > SAT_HI) begin
        dir_c[i*CB +: CB] = SAT_HI[CB-1:0];
      end else if (cmp_r[i] < SAT_LO) begin
        dir_c[i*CB +: CB] = SAT_LO[CB-1:0];
      end else begin
        dir_c[i*CB +: CB] = cmp_r[i][CB-1:0];
      end
      col_c[i*CB +: CB] = col_r[S_SUM][i];
    end
    nz_c = |dir_c;
  end

  always_ff @(posedge clk) begin
    if (en[LAT]) begin
      ob_r <= surv_r[S_SUM] & nz_c;
      od_r <= (surv_r[S_SUM] & nz_c) ? dir_c : '0;
      oc_r <= surv_r[S_SUM] ? col_c : '0;
    end
  end

  assign out_valid              = vld_r[LAT];
  assign out_bounce_valid       = ob_r;
  assign out_outgoing_direction = od_r;
  assign out_bounce_color       = oc_r;

  // ---------------- checks
  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("pipe drained but input stalled");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[1])
    else $error("accepted word not in first stage");

  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bounce_valid |-> out_outgoing_direction == '0)
    else $error("direction set on invalid bounce");

  a_live_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bounce_valid |-> out_outgoing_direction != '0)
    else $error("valid bounce with zero direction");

endmodule

// ===== verif/chsb_bounce_checker.sv =====
// Watches both channels of the bounce sampler, predicts each result from the
// accepted input word and compares it with the next output word.
module chsb_bounce_checker import chsb_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic [VW-1:0] in_surface_normal,
  input  logic [VW-1:0] in_surface_tangent,
  input  logic [VW-1:0] in_incoming_direction,
  input  logic [VW-1:0] in_surface_reflectivity,
  input  logic [CB-1:0] in_rand_roulette,
  input  logic [CB-1:0] in_rand_angle,
  input  logic [CB-1:0] in_rand_radius,
  input  logic          out_valid,
  input  logic          out_ready,
  input  logic          out_bounce_valid,
  input  logic [VW-1:0] out_outgoing_direction,
  input  logic [VW-1:0] out_bounce_color,
  output int            fail_count,
  output int            pending,
  output int            bounces_seen,
  output int            kills_seen
);

  typedef struct {
    logic          alive;
    logic [VW-1:0] dir;
    logic [VW-1:0] color;
  } bounce_t;

  bounce_t bounce_q[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned taylor_step(longint unsigned acc,
      longint unsigned x2, longint unsigned k);
    return (64'd1 << 30) - ((x2 * acc) >> 30) / k;
  endfunction

  function automatic longint signed_part(logic [VW-1:0] w, int i);
    logic signed [CB-1:0] p;
    p = w[i*CB +: CB];
    return longint'(p);
  endfunction

  // cos/sin of u turns in Q2.30, quarter-turn fold plus Taylor residual
  task automatic angle_cos_sin(input longint unsigned u, output longint co,
      output longint si);
    longint unsigned ph, mag, a, x2, s, c;
    longint q, r, sv;
    ph = u << (32 - CB);
    q = longint'((ph + (64'd1 << 29)) >> 30);
    r = longint'(ph) - q * (64'sd1 <<< 30);
    mag = (r < 0) ? -r : r;
    a = (mag * (2 * 64'd3373259426)) >> 32;
    x2 = (a * a) >> 30;
    s = 64'd1 << 30;
    c = 64'd1 << 30;
    s = taylor_step(s, x2, 110); s = taylor_step(s, x2, 72);
    s = taylor_step(s, x2, 42);  s = taylor_step(s, x2, 20);
    s = taylor_step(s, x2, 6);
    s = (a * s) >> 30;
    c = taylor_step(c, x2, 132); c = taylor_step(c, x2, 90);
    c = taylor_step(c, x2, 56);  c = taylor_step(c, x2, 30);
    c = taylor_step(c, x2, 12);  c = taylor_step(c, x2, 2);
    sv = (r < 0) ? -longint'(s) : longint'(s);
    case (q & 3)
      0: begin co = c;   si = sv;  end
      1: begin co = -sv; si = c;   end
      2: begin co = -c;  si = -sv; end
      default: begin co = sv; si = -c; end
    endcase
  endtask

  task automatic predict_bounce(output bounce_t b);
    longint n[3], t[3], d[3], cb[3], xp[3];
    longint unsigned refl[3], total, sr, sz, num, q;
    longint co, si, xc, yc, dot, acc, comp, hi, lo;
    logic nz;
    hi = (64'sd1 <<< (CB - 1)) - 1;
    lo = -hi - 1;
    nz = 0;
    dot = 0;
    b.alive = 0; b.dir = '0; b.color = '0;
    for (int i = 0; i < 3; i++) begin
      n[i] = signed_part(in_surface_normal, i);
      t[i] = signed_part(in_surface_tangent, i);
      d[i] = signed_part(in_incoming_direction, i);
      refl[i] = in_surface_reflectivity[i*CB +: CB];
    end
    total = refl[0] + refl[1] + refl[2];
    if (!(3 * longint'(in_rand_roulette) < total)) return;
    angle_cos_sin(in_rand_angle, co, si);
    sr = isqrt(longint'(in_rand_radius) << (60 - CB));
    sz = isqrt(((64'd1 << CB) - in_rand_radius) << (60 - CB));
    xc = floor_shift(co * longint'(sr), 30);
    yc = floor_shift(si * longint'(sr), 30);
    for (int i = 0; i < 3; i++) dot += n[i] * d[i];
    if (dot < 0) for (int i = 0; i < 3; i++) n[i] = -n[i];
    xp[0] = n[1] * t[2] - n[2] * t[1];
    xp[1] = n[2] * t[0] - n[0] * t[2];
    xp[2] = n[0] * t[1] - n[1] * t[0];
    for (int i = 0; i < 3; i++) cb[i] = floor_shift(xp[i], FB);
    for (int i = 0; i < 3; i++) begin
      acc = t[i] * xc + cb[i] * yc + n[i] * longint'(sz);
      comp = floor_shift(acc + (64'sd1 <<< 29), 30);
      if (comp > hi) comp = hi;
      if (comp < lo) comp = lo;
      if (comp != 0) nz = 1;
      b.dir[i*CB +: CB] = comp[CB-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      num = (3 * refl[i]) << (FB + 1);
      q = (num + total) / (2 * total);
      if (q > (64'd1 << CB) - 1) q = (64'd1 << CB) - 1;
      b.color[i*CB +: CB] = q[CB-1:0];
    end
    b.alive = nz;
    if (!nz) b.dir = '0;
  endtask

  always @(posedge clk) begin
    bounce_t exp_b;
    if (!rst_n) begin
      fail_count <= 0;
      bounces_seen <= 0;
      kills_seen <= 0;
      bounce_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_bounce(exp_b);
        bounce_q.push_back(exp_b);
      end
      if (out_valid && out_ready) begin
        if (bounce_q.size() == 0) begin
          $display("%0t: output word with nothing expected", $time);
          fail_count <= fail_count + 1;
        end else begin
          exp_b = bounce_q.pop_front();
          if (out_bounce_valid) bounces_seen <= bounces_seen + 1;
          else kills_seen <= kills_seen + 1;
          if (exp_b.alive !== out_bounce_valid || exp_b.dir !== out_outgoing_direction
              || exp_b.color !== out_bounce_color) begin
            $display("%0t: mismatch exp valid=%b dir=%h col=%h act valid=%b dir=%h col=%h",
                     $time, exp_b.alive, exp_b.dir, exp_b.color, out_bounce_valid,
                     out_outgoing_direction, out_bounce_color);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = bounce_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    bounces_seen = 0;
    kills_seen = 0;
  end

endmodule

// ===== verif/cosine_hemisphere_bounce_sampler_tb.sv =====
// Top of the bounce sampler bench: clock, reset, stimulus, back pressure and
// the verdict. All prediction and compare lives in the checker instance.
module cosine_hemisphere_bounce_sampler_tb;
  import chsb_pkg::*;

  localparam int RAND_WORDS = 1600;
  localparam int WATCHDOG   = 2000;   // idle cycles before the bench times out

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [VW-1:0] in_surface_normal;
  logic [VW-1:0] in_surface_tangent;
  logic [VW-1:0] in_incoming_direction;
  logic [VW-1:0] in_surface_reflectivity;
  logic [CB-1:0] in_rand_roulette;
  logic [CB-1:0] in_rand_angle;
  logic [CB-1:0] in_rand_radius;
  logic          out_valid;
  logic          out_ready;
  logic          out_bounce_valid;
  logic [VW-1:0] out_outgoing_direction;
  logic [VW-1:0] out_bounce_color;

  int  fail_count, pending, bounces_seen, kills_seen;
  int  idle_cycles;
  bit  stim_done;

  cosine_hemisphere_bounce_sampler u_dut (.*);

  chsb_bounce_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // most often no gap, else mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Q1.14 unit vector along the given axis, negated when neg is set
  function automatic logic [VW-1:0] axis_vec(int axis, bit neg);
    logic [VW-1:0] w;
    w = '0;
    w[axis*CB +: CB] = neg ? -16'sd16384 : 16'sd16384;
    return w;
  endfunction

  // random well-formed frame: n and t orthogonal unit axes, or a 45-degree tilt
  task automatic make_frame(output logic [VW-1:0] n, output logic [VW-1:0] t);
    int a, b;
    a = $urandom_range(0, 2);
    b = (a + $urandom_range(1, 2)) % 3;
    n = axis_vec(a, 1'($urandom_range(0, 1)));
    t = axis_vec(b, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) begin
      n = '0;
      n[a*CB +: CB] = 16'sd11585;
      n[b*CB +: CB] = 16'sd11585;
      t = '0;
      t[a*CB +: CB] = 16'sd11585;
      t[b*CB +: CB] = -16'sd11585;
    end
  endtask

  // valid stays up across back-to-back words; it drops only for a gap
  task automatic send_word(logic [VW-1:0] n, logic [VW-1:0] t, logic [VW-1:0] d,
      logic [VW-1:0] refl, logic [CB-1:0] rr, logic [CB-1:0] ra, logic [CB-1:0] rv);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_surface_normal <= n;
    in_surface_tangent <= t;
    in_incoming_direction <= d;
    in_surface_reflectivity <= refl;
    in_rand_roulette <= rr;
    in_rand_angle <= ra;
    in_rand_radius <= rv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [VW-1:0] rnd48();
    return VW'({$urandom(), $urandom()});
  endfunction

  // receiver: random stalls, with stretches of always-ready
  initial begin
    int g;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1;
        repeat ($urandom_range(5, 40)) @(negedge clk);
      end
      g = gap_len();
      if (g == 0) out_ready <= 1;
      else begin
        out_ready <= 0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // watchdog on accepted words of either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("cosine_hemisphere_bounce_sampler_tb: errors");
      $finish;
    end
  end

  initial begin
    logic [VW-1:0] n, t, d, refl, full_refl;
    int mode;
    rst_n = 0;
    in_valid = 0;
    stim_done = 0;
    idle_cycles = 0;
    in_surface_normal = '0;
    in_surface_tangent = '0;
    in_incoming_direction = '0;
    in_surface_reflectivity = '0;
    in_rand_roulette = '0;
    in_rand_angle = '0;
    in_rand_radius = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    full_refl = {3{16'hFFFF}};
    n = axis_vec(2, 0);
    t = axis_vec(0, 0);
    // directed: zero reflectivity always terminates
    send_word(n, t, n, '0, '0, 16'h1234, 16'h8000);
    // full and minimal reflectivity, roulette extremes
    send_word(n, t, n, full_refl, 16'h0000, 16'h0000, 16'h0000);
    send_word(n, t, n, full_refl, 16'hFFFF, 16'h0000, 16'h0000);
    send_word(n, t, n, {16'h0001, 16'h0000, 16'h0000}, 16'h0000, 16'h0, 16'h0);
    // incoming on the far side flips the normal
    send_word(n, t, axis_vec(2, 1), full_refl, 16'h0, 16'h2000, 16'h4000);
    // quarter turns and the residual edges
    for (int k = 0; k < 8; k++)
      send_word(n, t, n, full_refl, 16'h0, 16'(k * 16'h2000), 16'hC000);
    send_word(n, t, n, full_refl, 16'h0, 16'h1FFF, 16'hFFFF);
    send_word(n, t, n, full_refl, 16'h0, 16'hFFFF, 16'hFFFF);
    // zero vectors give a zero direction with color kept
    send_word('0, '0, '0, full_refl, 16'h0, 16'h5555, 16'h8000);
    // most negative and most positive codes in the vector fields
    send_word({3{16'h8000}}, {3{16'h8000}}, {3{16'h7FFF}}, full_refl, 16'h0,
              16'h1000, 16'h7000);
    send_word({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h8000}}, {16'hFFFF, 16'h0, 16'h1},
              16'h0, 16'hE000, 16'hFFFF);
    // one channel dominates the color: it reaches the largest quotient, 3*2^14
    send_word(n, t, n, {16'h0000, 16'h0000, 16'h0003}, 16'h0, 16'h0, 16'h1);
    send_word(rnd48(), rnd48(), rnd48(), rnd48(), 16'h0, 16'hFFFF, 16'h0);

    for (int i = 0; i < RAND_WORDS; i++) begin
      mode = $urandom_range(0, 9);
      make_frame(n, t);
      d = ($urandom_range(0, 1)) ? n : ~n + 1'b1;
      if ($urandom_range(0, 4) == 0) d = rnd48();
      refl = rnd48();
      if (mode >= 8) begin
        // noise: anything in every field
        send_word(rnd48(), rnd48(), rnd48(), refl, CB'($urandom()), CB'($urandom()),
                  CB'($urandom()));
      end else begin
        // mostly survivors: keep roulette below the mean
        send_word(n, t, d, refl,
                  (mode < 6) ? CB'($urandom_range(0, 21845)) : CB'($urandom()),
                  CB'($urandom()), CB'($urandom()));
      end
    end
    in_valid <= 0;
    stim_done = 1;

    while (pending != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    $display("sent %0d words: %0d live bounces, %0d terminated or zero direction",
             RAND_WORDS + 20, bounces_seen, kills_seen);
    if (fail_count == 0 && pending == 0)
      $display("cosine_hemisphere_bounce_sampler_tb: clean");
    else
      $display("cosine_hemisphere_bounce_sampler_tb: errors");
    $finish;
  end

endmodule
